>>> hdl/dti_pkg.sv
// Package for the decision tree classifier: sizes, codes and shared types.
package dti_pkg;

    // Table and buffer sizes
    localparam int MAX_NODES      = 256;
    localparam int MAX_FEATURES   = 16;
    localparam int MAX_CLASSES    = 16;
    localparam int MAX_WALK_DEPTH = 32;

    localparam int NODE_AW  = $clog2(MAX_NODES);
    localparam int FEAT_AW  = $clog2(MAX_FEATURES);
    localparam int CLASS_W  = $clog2(MAX_CLASSES);
    localparam int STEP_W   = $clog2(MAX_WALK_DEPTH + 1);
    localparam int CNT_W    = 5;
    localparam int CNT_MAX  = 31;
    localparam int VALUE_W  = 32;

    // Command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 16;

    // Input beat kinds (tuser)
    localparam logic KIND_NODE    = 1'b0;
    localparam logic KIND_FEATURE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_TREE  = 2'd1,
        STAT_MISMATCH = 2'd2,
        STAT_DEPTH    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_NODE_WR = 2'd0,
        CMD_WALK    = 2'd1,
        CMD_ERROR   = 2'd2
    } t_cmd_kind;

    // One node table entry
    typedef struct packed {
        logic                 is_leaf;
        logic [FEAT_AW-1:0]   feature;
        logic [VALUE_W-1:0]   threshold;
        logic [NODE_AW-1:0]   left;
        logic [NODE_AW-1:0]   right;
        logic [CLASS_W-1:0]   cls;
    } t_node;

    // Queue entry: node write, walk request or ready-made error result
    typedef struct packed {
        t_cmd_kind            kind;
        logic [NODE_AW-1:0]   addr;
        t_node                node;
        t_status              status;
    } t_cmd;

    // Back to front: feature lookup and walk completion
    typedef struct packed {
        logic                 walk_done;
        logic [FEAT_AW-1:0]   feat_idx;
    } t_back_stat;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_OUT  = 2'd2
    } t_walk_state;

endpackage

>>> hdl/dti_fifo.sv
// Short command queue between the front and back of the classifier.
module dti_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dti_pkg::t_cmd i_data,
    input  logic          i_pop,
    output dti_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);

    dti_pkg::t_cmd r_mem [dti_pkg::FIFO_DEPTH];
    logic [dti_pkg::FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [dti_pkg::FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [dti_pkg::FIFO_AW:0]   r_count,  n_count;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (dti_pkg::FIFO_AW+1)'(dti_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");

endmodule

>>> hdl/dti_front.sv
// Front of the classifier: accepts beats, fills the feature buffer, checks errors.
module dti_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dti_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [dti_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tlast,
    input  logic                          i_s_tuser,
    output logic                          o_push,
    output dti_pkg::t_cmd                 o_cmd,
    input  logic                          i_full,
    input  dti_pkg::t_back_stat           i_back,
    output logic [dti_pkg::VALUE_W-1:0]   o_feat_value
);

    logic [dti_pkg::CNT_W-1:0]   r_cfg;
    logic [dti_pkg::CNT_W-1:0]   r_feat_cnt, n_feat_cnt;
    logic                        r_loaded,   n_loaded;
    logic                        r_busy,     n_busy;
    logic [dti_pkg::VALUE_W-1:0] r_fbuf [dti_pkg::MAX_FEATURES];

    logic                        accept;
    logic [dti_pkg::CNT_W-1:0]   count_sat;
    logic [dti_pkg::VALUE_W-1:0] feat_value;
    dti_pkg::t_cmd               cmd;

    assign feat_value = i_s_tdata[96:65];
    assign o_s_tready = !i_full && !r_busy;
    assign accept     = i_s_tvalid && o_s_tready;
    assign count_sat  = (r_feat_cnt < dti_pkg::CNT_W'(dti_pkg::CNT_MAX))
                        ? r_feat_cnt + 1'b1 : r_feat_cnt;

    // Build the queue command for this beat
    always_comb begin
        cmd.kind           = dti_pkg::CMD_NODE_WR;
        cmd.addr           = i_s_tdata[7:0];
        cmd.node.is_leaf   = i_s_tdata[8];
        cmd.node.feature   = i_s_tdata[12:9];
        cmd.node.threshold = i_s_tdata[44:13];
        cmd.node.left      = i_s_tdata[52:45];
        cmd.node.right     = i_s_tdata[60:53];
        cmd.node.cls       = i_s_tdata[64:61];
        cmd.status         = dti_pkg::STAT_OK;
        if (i_s_tuser == dti_pkg::KIND_FEATURE) begin
            if (!r_loaded) begin
                cmd.kind   = dti_pkg::CMD_ERROR;
                cmd.status = dti_pkg::STAT_NO_TREE;
            end else if (count_sat != r_cfg) begin
                cmd.kind   = dti_pkg::CMD_ERROR;
                cmd.status = dti_pkg::STAT_MISMATCH;
            end else begin
                cmd.kind   = dti_pkg::CMD_WALK;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && ((i_s_tuser == dti_pkg::KIND_NODE) || i_s_tlast);

    // Counter, tree-loaded flag and walk-busy flag
    always_comb begin
        n_feat_cnt = r_feat_cnt;
        n_loaded   = r_loaded;
        n_busy     = r_busy;
        if (i_back.walk_done) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            if (i_s_tuser == dti_pkg::KIND_NODE) begin
                if (cmd.addr == '0) begin
                    n_loaded = 1'b1;
                end
            end else if (i_s_tlast) begin
                n_feat_cnt = '0;
                if (cmd.kind == dti_pkg::CMD_WALK) begin
                    n_busy = 1'b1;
                end
            end else begin
                n_feat_cnt = count_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= dti_pkg::CNT_W'(1);
            r_feat_cnt <= '0;
            r_loaded   <= 1'b0;
            r_busy     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_feat_cnt <= n_feat_cnt;
            r_loaded   <= n_loaded;
            r_busy     <= n_busy;
        end
    end

    // Feature buffer; values past its end are counted only
    always_ff @(posedge i_clk) begin
        if (accept && (i_s_tuser == dti_pkg::KIND_FEATURE)
            && (r_feat_cnt < dti_pkg::CNT_W'(dti_pkg::MAX_FEATURES))) begin
            r_fbuf[r_feat_cnt[dti_pkg::FEAT_AW-1:0]] <= feat_value;
        end
    end

    // Lookup for the walk: indexes at or past the configured count read zero
    assign o_feat_value = ({1'b0, i_back.feat_idx} >= r_cfg) ? '0 : r_fbuf[i_back.feat_idx];

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_s_tready) else $error("beat accepted during walk");

endmodule

>>> hdl/dti_back.sv
// Back of the classifier: node table, tree walk and result register.
module dti_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dti_pkg::t_cmd                 i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output dti_pkg::t_back_stat           o_stat,
    input  logic [dti_pkg::VALUE_W-1:0]   i_feat_value,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [dti_pkg::M_TDATA_W-1:0] o_m_tdata
);

    dti_pkg::t_walk_state r_state, n_state;

    dti_pkg::t_node                r_mem [dti_pkg::MAX_NODES];
    dti_pkg::t_node                r_rd_node;
    logic [dti_pkg::NODE_AW-1:0]   r_cur,   n_cur;
    logic [dti_pkg::STEP_W-1:0]    r_steps, n_steps;
    logic [dti_pkg::CLASS_W-1:0]   r_cls,   n_cls;
    logic [dti_pkg::NODE_AW-1:0]   r_leaf,  n_leaf;
    dti_pkg::t_status              r_status, n_status;

    logic                          mem_we;
    logic [dti_pkg::NODE_AW-1:0]   rd_addr;
    logic [dti_pkg::NODE_AW-1:0]   nxt;
    logic                          go_left;
    logic                          walk_done;
    logic                          at_limit;

    assign go_left  = ($signed(i_feat_value) <= $signed(r_rd_node.threshold));
    assign nxt      = go_left ? r_rd_node.left : r_rd_node.right;
    assign at_limit = (r_steps == dti_pkg::STEP_W'(dti_pkg::MAX_WALK_DEPTH));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dti_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    if (i_head.kind == dti_pkg::CMD_WALK) begin
                        n_state = dti_pkg::ST_WALK;
                    end else if (i_head.kind == dti_pkg::CMD_ERROR) begin
                        n_state = dti_pkg::ST_OUT;
                    end
                end
            end
            dti_pkg::ST_WALK: begin
                if (r_rd_node.is_leaf || at_limit) begin
                    n_state = dti_pkg::ST_OUT;
                end
            end
            dti_pkg::ST_OUT: begin
                if (i_m_tready) begin
                    n_state = dti_pkg::ST_IDLE;
                end
            end
            default: n_state = dti_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath controls
    always_comb begin
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        walk_done = 1'b0;
        rd_addr   = r_cur;
        n_cur     = r_cur;
        n_steps   = r_steps;
        n_cls     = r_cls;
        n_leaf    = r_leaf;
        n_status  = r_status;
        unique case (r_state)
            dti_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_head.kind)
                        dti_pkg::CMD_NODE_WR: mem_we = 1'b1;
                        dti_pkg::CMD_WALK: begin
                            rd_addr = '0;
                            n_cur   = '0;
                            n_steps = '0;
                        end
                        default: begin
                            n_cls    = '0;
                            n_leaf   = '0;
                            n_status = i_head.status;
                        end
                    endcase
                end
            end
            dti_pkg::ST_WALK: begin
                if (r_rd_node.is_leaf) begin
                    walk_done = 1'b1;
                    n_cls     = r_rd_node.cls;
                    n_leaf    = r_cur;
                    n_status  = dti_pkg::STAT_OK;
                end else if (at_limit) begin
                    walk_done = 1'b1;
                    n_cls     = '0;
                    n_leaf    = '0;
                    n_status  = dti_pkg::STAT_DEPTH;
                end else begin
                    rd_addr = nxt;
                    n_cur   = nxt;
                    n_steps = r_steps + 1'b1;
                end
            end
            dti_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dti_pkg::ST_IDLE;
            r_cur   <= '0;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_steps <= n_steps;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_cls    <= n_cls;
        r_leaf   <= n_leaf;
        r_status <= n_status;
    end

    // Node table, at most one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_head.addr] <= i_head.node;
        end
        r_rd_node <= r_mem[rd_addr];
    end

    assign o_stat.walk_done = walk_done;
    assign o_stat.feat_idx  = r_rd_node.feature;

    assign o_m_tvalid = (r_state == dti_pkg::ST_OUT);
    assign o_m_tdata  = {2'b00, r_status, r_leaf, r_cls};

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= dti_pkg::STEP_W'(dti_pkg::MAX_WALK_DEPTH))
        else $error("walk step count past limit");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_status != dti_pkg::STAT_OK)) |-> (r_cls == '0 && r_leaf == '0))
        else $error("error result with nonzero class or leaf");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != dti_pkg::ST_IDLE) |-> !o_pop)
        else $error("queue popped while walking or holding a result");

endmodule

>>> hdl/decision_tree_inference.sv
// Flow: a closing feature beat is queued; the back pops it, walks the tree from node 0
// to a leaf or the depth limit, then raises o_m_tvalid; an error result skips the walk.
// Throughput: one node beat per cycle while the queue has room and no walk runs; every
// beat stalls during a walk, so a new sample is taken only after the last walk is done.
// Reset (synchronous, active low) clears queue, counters, flags and state and sets the
// feature count register to 1; node table and feature buffer keep their contents.
module decision_tree_inference (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dti_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // node_addr, node_is_leaf, node_feature, node_threshold, node_left,
    // node_right, node_class, feature_value, zero fill
    input  logic [dti_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tlast,
    // kind
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // predicted_class, leaf_index, status, zero fill
    output logic [dti_pkg::M_TDATA_W-1:0] o_m_tdata
);

    logic                        push;
    logic                        pop;
    logic                        full;
    logic                        empty;
    dti_pkg::t_cmd               cmd_in;
    dti_pkg::t_cmd               cmd_head;
    dti_pkg::t_back_stat         back_stat;
    logic [dti_pkg::VALUE_W-1:0] feat_value;

    // Intake and error checks
    dti_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_s_tuser    (i_s_tuser),
        .o_push       (push),
        .o_cmd        (cmd_in),
        .i_full       (full),
        .i_back       (back_stat),
        .o_feat_value (feat_value)
    );

    // Command queue
    dti_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .i_pop   (pop),
        .o_head  (cmd_head),
        .o_full  (full),
        .o_empty (empty)
    );

    // Node table and walk
    dti_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (cmd_head),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_stat       (back_stat),
        .i_feat_value (feat_value),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

endmodule
